### design/dre_pkg.sv
// ----------------------------------------------------------------------------
// dre_pkg: shared types and constants for the DNS A-record extractor
// Parse phases, result status codes and fixed DNS header offsets.
// ----------------------------------------------------------------------------
`default_nettype none

package dre_pkg;

  // Parse phases of the byte walker
  typedef enum logic [3:0] {
    PH_HEADER,
    PH_Q_NAME,
    PH_Q_LABEL,
    PH_Q_TAIL,
    PH_A_START,
    PH_A_PTR2,
    PH_A_NAME,
    PH_A_LABEL,
    PH_A_FIXED,
    PH_A_DATA,
    PH_A_SKIPDATA,
    PH_DONE
  } dre_phase_t;

  // Result status codes
  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_NONE  = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  // Header layout (byte offsets)
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned QDCOUNT_HI   = 4;
  localparam int unsigned QDCOUNT_LO   = 5;
  localparam int unsigned ANCOUNT_HI   = 6;
  localparam int unsigned ANCOUNT_LO   = 7;

  // Compressed-name pointer marker (top two bits set)
  localparam logic [7:0] PTR_MASK = 8'hC0;

  // Fixed record fields: type(2) class(2) ttl(4) rdlength(2)
  localparam logic [3:0] FIX_CLASS_START = 4'd2;
  localparam logic [3:0] FIX_TTL_START   = 4'd4;
  localparam logic [3:0] FIX_RDLEN_START = 4'd8;
  localparam logic [3:0] FIX_LAST        = 4'd9;
  localparam logic [3:0] ADDR_LAST       = 4'd3;

  // Accepted A record: type 1, class IN, 4 data bytes
  localparam logic [15:0] TYPE_A   = 16'd1;
  localparam logic [15:0] CLASS_IN = 16'd1;
  localparam logic [15:0] A_RDLEN  = 16'd4;
  localparam logic [15:0] Q_TAIL_BYTES = 16'd4;

  // One result word
  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  status;
  } dre_result_t;

endpackage

`default_nettype wire

### design/dre_parser.sv
// ----------------------------------------------------------------------------
// dre_parser: DNS response byte walker
// Updates the parse state on every accepted byte within MAX_MESSAGE_BYTES and forms the result for
// the byte that closes the message. State returns to reset after that byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dre_parser #(
  parameter int MAX_MESSAGE_BYTES = 512
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  byte_accept,
  input  wire [7:0]            data_byte,
  input  wire                  last_byte,
  output dre_pkg::dre_result_t result
);
  import dre_pkg::*;

  localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

  dre_phase_t  phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] qleft_r, qleft_nxt;
  logic [15:0] aleft_r, aleft_nxt;
  logic [3:0]  fshift_r, fshift_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [15:0] rclass_r, rclass_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        found_r, found_nxt;

  logic        consume;
  logic [15:0] skip_dec, qleft_dec, aleft_dec;
  logic [3:0]  fshift_inc;
  logic [POS_W-1:0] pos_count;

  // Bytes past the buffer are neither parsed nor counted
  assign consume    = byte_accept && (pos_r < POS_W'(MAX_MESSAGE_BYTES));
  assign skip_dec   = skip_r - 16'd1;
  assign qleft_dec  = qleft_r - 16'd1;
  assign aleft_dec  = aleft_r - 16'd1;
  assign fshift_inc = fshift_r + 4'd1;
  assign pos_count  = consume ? pos_r + POS_W'(1) : pos_r;

  // Field datapath
  always_comb begin
    skip_nxt   = skip_r;
    qleft_nxt  = qleft_r;
    aleft_nxt  = aleft_r;
    fshift_nxt = fshift_r;
    rtype_nxt  = rtype_r;
    rclass_nxt = rclass_r;
    addr_nxt   = addr_r;
    found_nxt  = found_r;
    if (consume) begin
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_W'(QDCOUNT_HI) || pos_r == POS_W'(QDCOUNT_LO)) begin
            qleft_nxt = {qleft_r[7:0], data_byte};
          end
          if (pos_r == POS_W'(ANCOUNT_HI) || pos_r == POS_W'(ANCOUNT_LO)) begin
            aleft_nxt = {aleft_r[7:0], data_byte};
          end
        end
        PH_Q_NAME, PH_A_NAME: begin
          skip_nxt = (data_byte == 8'd0 && phase_r == PH_Q_NAME) ? Q_TAIL_BYTES
                                                               : {8'd0, data_byte};
          if (data_byte == 8'd0 && phase_r == PH_A_NAME) begin
            fshift_nxt = 4'd0;
            rtype_nxt  = 16'd0;
            rclass_nxt = 16'd0;
            skip_nxt   = 16'd0;
          end
        end
        PH_Q_LABEL, PH_A_LABEL, PH_A_SKIPDATA: begin
          skip_nxt = skip_dec;
          if (phase_r == PH_A_SKIPDATA && skip_dec == 16'd0) begin
            aleft_nxt = aleft_dec;
          end
        end
        PH_Q_TAIL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            qleft_nxt = qleft_dec;
          end
        end
        PH_A_START: begin
          if ((data_byte & PTR_MASK) == PTR_MASK) begin
            skip_nxt = skip_r;
          end else if (data_byte == 8'd0) begin
            fshift_nxt = 4'd0;
            rtype_nxt  = 16'd0;
            rclass_nxt = 16'd0;
            skip_nxt   = 16'd0;
          end else begin
            skip_nxt = {8'd0, data_byte};
          end
        end
        PH_A_PTR2: begin
          fshift_nxt = 4'd0;
          rtype_nxt  = 16'd0;
          rclass_nxt = 16'd0;
          skip_nxt   = 16'd0;
        end
        PH_A_FIXED: begin
          if (fshift_r < FIX_CLASS_START) begin
            rtype_nxt = {rtype_r[7:0], data_byte};
          end else if (fshift_r < FIX_TTL_START) begin
            rclass_nxt = {rclass_r[7:0], data_byte};
          end else if (fshift_r >= FIX_RDLEN_START) begin
            skip_nxt = {skip_r[7:0], data_byte};
          end
          fshift_nxt = fshift_inc;
          if (fshift_r == FIX_LAST) begin
            if (rtype_r == TYPE_A && rclass_r == CLASS_IN &&
                {skip_r[7:0], data_byte} == A_RDLEN) begin
              fshift_nxt = 4'd0;
              addr_nxt   = 32'd0;
            end else if ({skip_r[7:0], data_byte} == 16'd0) begin
              aleft_nxt = aleft_dec;
            end
          end
        end
        PH_A_DATA: begin
          addr_nxt   = {addr_r[23:0], data_byte};
          fshift_nxt = fshift_inc;
          if (fshift_r >= ADDR_LAST) begin
            found_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (consume) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_W'(HEADER_BYTES - 1)) begin
            if (qleft_r != 16'd0)      phase_nxt = PH_Q_NAME;
            else if (aleft_r != 16'd0) phase_nxt = PH_A_START;
            else                       phase_nxt = PH_DONE;
          end
        end
        PH_Q_NAME: begin
          phase_nxt = (data_byte == 8'd0) ? PH_Q_TAIL : PH_Q_LABEL;
        end
        PH_Q_LABEL: begin
          if (skip_dec == 16'd0) phase_nxt = PH_Q_NAME;
        end
        PH_Q_TAIL: begin
          if (skip_dec == 16'd0) begin
            if (qleft_dec != 16'd0)    phase_nxt = PH_Q_NAME;
            else if (aleft_r != 16'd0) phase_nxt = PH_A_START;
            else                       phase_nxt = PH_DONE;
          end
        end
        PH_A_START: begin
          if ((data_byte & PTR_MASK) == PTR_MASK) phase_nxt = PH_A_PTR2;
          else if (data_byte == 8'd0)             phase_nxt = PH_A_FIXED;
          else                                    phase_nxt = PH_A_LABEL;
        end
        PH_A_PTR2: phase_nxt = PH_A_FIXED;
        PH_A_NAME: begin
          phase_nxt = (data_byte == 8'd0) ? PH_A_FIXED : PH_A_LABEL;
        end
        PH_A_LABEL: begin
          if (skip_dec == 16'd0) phase_nxt = PH_A_NAME;
        end
        PH_A_FIXED: begin
          if (fshift_r == FIX_LAST) begin
            if (rtype_r == TYPE_A && rclass_r == CLASS_IN &&
                {skip_r[7:0], data_byte} == A_RDLEN) begin
              phase_nxt = PH_A_DATA;
            end else if ({skip_r[7:0], data_byte} == 16'd0) begin
              phase_nxt = (aleft_dec != 16'd0) ? PH_A_START : PH_DONE;
            end else begin
              phase_nxt = PH_A_SKIPDATA;
            end
          end
        end
        PH_A_DATA: begin
          if (fshift_r >= ADDR_LAST) phase_nxt = PH_DONE;
        end
        PH_A_SKIPDATA: begin
          if (skip_dec == 16'd0) begin
            phase_nxt = (aleft_dec != 16'd0) ? PH_A_START : PH_DONE;
          end
        end
        PH_DONE: phase_nxt = PH_DONE;
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // Result for the closing byte
  always_comb begin
    if (found_nxt) begin
      result.status  = STATUS_FOUND;
      result.address = addr_nxt;
    end else begin
      result.status  = (pos_count < POS_W'(HEADER_BYTES)) ? STATUS_SHORT : STATUS_NONE;
      result.address = 32'd0;
    end
  end

  // State registers; the closing byte returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (byte_accept && last_byte)) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      skip_r   <= '0;
      qleft_r  <= '0;
      aleft_r  <= '0;
      fshift_r <= '0;
      rtype_r  <= '0;
      rclass_r <= '0;
      addr_r   <= '0;
      found_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_count;
      skip_r   <= skip_nxt;
      qleft_r  <= qleft_nxt;
      aleft_r  <= aleft_nxt;
      fshift_r <= fshift_nxt;
      rtype_r  <= rtype_nxt;
      rclass_r <= rclass_nxt;
      addr_r   <= addr_nxt;
      found_r  <= found_nxt;
    end
  end

endmodule

`default_nettype wire

### design/dns_response_a_record_extractor.sv
// ----------------------------------------------------------------------------
// dns_response_a_record_extractor: first IPv4 address from a DNS response
// Streams a DNS response one byte per word and reports the first A record.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock cycle with no gaps required,
// tlast marking the final byte. The parse state updates in the cycle a byte
// is accepted; one result word appears on the output register the cycle
// after the last byte, carrying status (found, no A record, or fewer than
// 12 bytes) and the address. Input ready drops only while a result is held
// and the output side is stalled. Bytes beyond MAX_MESSAGE_BYTES are not
// parsed but their tlast still closes the message.
`default_nettype none

module dns_response_a_record_extractor #(
  parameter int MAX_MESSAGE_BYTES = 512
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tlast,   // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata   // [1:0] status, [33:2] address, [39:34] zero
);
  import dre_pkg::*;

  logic        in_accept;
  dre_result_t result;
  dre_result_t out_res_r;
  logic        out_valid_r, out_valid_nxt;

  // Output register frees in the same cycle it is taken
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  dre_parser #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_accept(in_accept),
    .data_byte  (in_tdata),
    .last_byte  (in_tlast),
    .result     (result)
  );

  // Result register control
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept && in_tlast)  out_valid_nxt = 1'b1;
    else if (out_tready)        out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_tlast) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.address, out_res_r.status};

endmodule

`default_nettype wire
